// ===== hw/rtl/hksp_pkg.sv =====
// ----------------------------------------------------------------------------
// hksp_pkg
// Shared types and constants of the keyframe NAL splitter.
// ----------------------------------------------------------------------------
package hksp_pkg;

    localparam int POS_BITS = 20;
    localparam int OFFSET_W = 20;
    localparam int LENGTH_W = 21;
    localparam int TIME_W   = 32;
    localparam int INDEX_W  = 2;

    typedef logic [POS_BITS-1:0] pos_t;
    typedef logic [POS_BITS:0]   plen_t;
    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [LENGTH_W-1:0] length_t;
    typedef logic [TIME_W-1:0]   time_t;
    typedef logic [INDEX_W-1:0]  index_t;

    localparam pos_t POS_MAX = {POS_BITS{1'b1}};

    // Input kinds carried on s_tuser.
    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_RESYNC = 1'b1;

    // NAL header fields.
    localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
    localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
    localparam logic [4:0] NAL_TYPE_IDR  = 5'd5;
    localparam logic [7:0] BYTE_ZERO     = 8'h00;
    localparam logic [7:0] BYTE_ONE      = 8'h01;

    // Number of start codes found so far.
    localparam logic [1:0] STAGE_NONE = 2'd0;
    localparam logic [1:0] STAGE_ONE  = 2'd1;
    localparam logic [1:0] STAGE_TWO  = 2'd2;
    localparam logic [1:0] STAGE_DONE = 2'd3;

    // Segment indexes.
    localparam index_t SEG_SPS  = 2'd0;
    localparam index_t SEG_PPS  = 2'd1;
    localparam index_t SEG_REST = 2'd2;

    // Everything needed to send the descriptors of one closed unit.
    typedef struct packed {
        logic    is_sps;
        length_t len0;
        offset_t off1;
        length_t len1;
        offset_t off2;
        length_t len2;
        time_t   stamp;
    } unit_rec_t;

endpackage

// ===== hw/rtl/hksp_scanner.sv =====
// ----------------------------------------------------------------------------
// hksp_scanner
// Per-byte start code scan; closes each unit not dropped while waiting into a descriptor record.
// ----------------------------------------------------------------------------
module hksp_scanner (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_op,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  hksp_pkg::time_t      in_stamp,
    output logic                 rec_valid,
    input  logic                 rec_ready,
    output hksp_pkg::unit_rec_t  rec
);

    logic                 waiting_reg, waiting_next;
    hksp_pkg::pos_t       pos_reg, pos_next;
    logic [7:0]           win_reg [5];
    logic [7:0]           win_next [5];
    logic [4:0]           type_reg, type_next;
    logic [1:0]           stage_reg, stage_next;
    hksp_pkg::pos_t       fb_reg, fb_next;
    hksp_pkg::pos_t       sb_reg, sb_next;
    hksp_pkg::pos_t       ts3_reg, ts3_next;
    logic                 skip_reg, skip_next;
    logic                 rec_valid_reg, rec_valid_next;
    hksp_pkg::unit_rec_t  rec_reg, rec_next;

    logic                 accept;
    logic                 stored;
    logic                 three, four, match;
    logic [7:0]           hdr;
    hksp_pkg::pos_t       scan_pos;
    hksp_pkg::plen_t      unit_len;
    logic                 waiting_after;
    logic                 emit;
    logic                 found1, found2, found3;

    assign in_ready  = !(rec_valid_reg && !rec_ready);
    assign accept    = in_valid && in_ready;
    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    always_comb begin
        waiting_next   = waiting_reg;
        pos_next       = pos_reg;
        win_next       = win_reg;
        type_next      = type_reg;
        stage_next     = stage_reg;
        fb_next        = fb_reg;
        sb_next        = sb_reg;
        ts3_next       = ts3_reg;
        skip_next      = skip_reg;
        rec_valid_next = rec_valid_reg && !rec_ready;
        rec_next       = rec_reg;

        stored   = pos_reg != hksp_pkg::POS_MAX;
        scan_pos = pos_reg - hksp_pkg::pos_t'(4);
        // A byte past the counter limit is not stored; the length still reads
        // one beyond the last position.
        unit_len = {1'b0, pos_reg} + hksp_pkg::plen_t'(1);

        // The tested window is win_reg[1..4] followed by in_byte.
        three = (win_reg[1] == hksp_pkg::BYTE_ZERO) && (win_reg[2] == hksp_pkg::BYTE_ZERO)
             && (win_reg[3] == hksp_pkg::BYTE_ONE);
        four  = (win_reg[1] == hksp_pkg::BYTE_ZERO) && (win_reg[2] == hksp_pkg::BYTE_ZERO)
             && (win_reg[3] == hksp_pkg::BYTE_ZERO) && (win_reg[4] == hksp_pkg::BYTE_ONE);
        match = three || four;
        // The NAL header follows the start code: in_byte for a 4-byte code.
        hdr   = (win_reg[3] == hksp_pkg::BYTE_ONE) ? win_reg[4] : in_byte;

        waiting_after = waiting_reg;
        emit          = 1'b0;
        found1        = 1'b0;
        found2        = 1'b0;
        found3        = 1'b0;

        if (accept) begin
            if (in_op == hksp_pkg::OP_RESYNC) begin
                waiting_next = 1'b1;
            end else begin
                if (stored) begin
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    win_next[2] = win_reg[3];
                    win_next[3] = win_reg[4];
                    win_next[4] = in_byte;
                    if (pos_reg == hksp_pkg::pos_t'(4)) begin
                        type_next = in_byte[4:0] & hksp_pkg::NAL_TYPE_MASK;
                    end
                    if (pos_reg >= hksp_pkg::pos_t'(8) && stage_reg != hksp_pkg::STAGE_DONE)
                    begin
                        if (skip_reg) begin
                            skip_next = 1'b0;
                        end else if (match) begin
                            skip_next = 1'b1;
                            unique case (stage_reg)
                                hksp_pkg::STAGE_NONE: begin
                                    fb_next    = scan_pos;
                                    stage_next = hksp_pkg::STAGE_ONE;
                                end
                                hksp_pkg::STAGE_ONE: begin
                                    sb_next    = scan_pos;
                                    stage_next = hksp_pkg::STAGE_TWO;
                                    if ((hdr[4:0] & hksp_pkg::NAL_TYPE_MASK)
                                        == hksp_pkg::NAL_TYPE_IDR) begin
                                        ts3_next   = scan_pos;
                                        stage_next = hksp_pkg::STAGE_DONE;
                                    end
                                end
                                default: begin
                                    ts3_next   = scan_pos;
                                    stage_next = hksp_pkg::STAGE_DONE;
                                end
                            endcase
                        end
                    end
                    pos_next = pos_reg + hksp_pkg::pos_t'(1);
                end

                if (in_last) begin
                    if (type_next == hksp_pkg::NAL_TYPE_SPS) begin
                        waiting_after = 1'b0;
                    end
                    waiting_next = waiting_after;
                    emit         = !waiting_after;

                    found1 = stage_next != hksp_pkg::STAGE_NONE;
                    found2 = stage_next == hksp_pkg::STAGE_TWO
                          || stage_next == hksp_pkg::STAGE_DONE;
                    found3 = stage_next == hksp_pkg::STAGE_DONE;

                    if (emit) begin
                        rec_valid_next = 1'b1;
                        rec_next.stamp = in_stamp;
                        rec_next.is_sps = type_next == hksp_pkg::NAL_TYPE_SPS;
                        if (type_next == hksp_pkg::NAL_TYPE_SPS) begin
                            rec_next.len0 = found1 ? hksp_pkg::length_t'(fb_next) : '0;
                        end else begin
                            rec_next.len0 = hksp_pkg::length_t'(unit_len);
                        end
                        rec_next.off1 = found2 ? hksp_pkg::offset_t'(fb_next) : '0;
                        rec_next.len1 = found2 ? hksp_pkg::length_t'(sb_next - fb_next) : '0;
                        rec_next.off2 = found3 ? hksp_pkg::offset_t'(ts3_next) : '0;
                        rec_next.len2 = found3
                            ? hksp_pkg::length_t'(unit_len - {1'b0, ts3_next}) : '0;
                    end

                    // Every closed unit starts the next one from a clean state.
                    pos_next   = '0;
                    win_next   = '{default: '0};
                    type_next  = '0;
                    stage_next = hksp_pkg::STAGE_NONE;
                    fb_next    = '0;
                    sb_next    = '0;
                    ts3_next   = '0;
                    skip_next  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waiting_reg   <= 1'b1;
            pos_reg       <= '0;
            win_reg       <= '{default: '0};
            type_reg      <= '0;
            stage_reg     <= hksp_pkg::STAGE_NONE;
            fb_reg        <= '0;
            sb_reg        <= '0;
            ts3_reg       <= '0;
            skip_reg      <= 1'b0;
            rec_valid_reg <= 1'b0;
        end else begin
            waiting_reg   <= waiting_next;
            pos_reg       <= pos_next;
            win_reg       <= win_next;
            type_reg      <= type_next;
            stage_reg     <= stage_next;
            fb_reg        <= fb_next;
            sb_reg        <= sb_next;
            ts3_reg       <= ts3_next;
            skip_reg      <= skip_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

endmodule

// ===== hw/rtl/hksp_emitter.sv =====
// ----------------------------------------------------------------------------
// hksp_emitter
// Sends the one or three segment descriptors of each closed unit.
// ----------------------------------------------------------------------------
module hksp_emitter (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rec_valid,
    output logic                 rec_ready,
    input  hksp_pkg::unit_rec_t  rec,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hksp_pkg::offset_t    out_offset,
    output hksp_pkg::length_t    out_length,
    output hksp_pkg::index_t     out_index,
    output hksp_pkg::time_t      out_time,
    output logic                 out_last
);

    logic                 busy_reg, busy_next;
    hksp_pkg::index_t     beat_reg, beat_next;
    hksp_pkg::unit_rec_t  cur_reg, cur_next;
    logic                 last_beat;
    logic                 load;

    assign last_beat = !cur_reg.is_sps || (beat_reg == hksp_pkg::SEG_REST);
    assign rec_ready = !busy_reg || (out_ready && last_beat);
    assign load      = rec_valid && rec_ready;

    always_comb begin
        busy_next = busy_reg;
        beat_next = beat_reg;
        cur_next  = cur_reg;
        if (load) begin
            busy_next = 1'b1;
            beat_next = hksp_pkg::SEG_SPS;
            cur_next  = rec;
        end else if (busy_reg && out_ready) begin
            if (last_beat) begin
                busy_next = 1'b0;
            end else begin
                beat_next = beat_reg + hksp_pkg::index_t'(1);
            end
        end
    end

    always_comb begin
        out_offset = '0;
        out_length = cur_reg.len0;
        unique case (beat_reg)
            hksp_pkg::SEG_PPS: begin
                out_offset = cur_reg.off1;
                out_length = cur_reg.len1;
            end
            hksp_pkg::SEG_REST: begin
                out_offset = cur_reg.off2;
                out_length = cur_reg.len2;
            end
            default: begin
                out_offset = '0;
                out_length = cur_reg.len0;
            end
        endcase
    end

    assign out_valid = busy_reg;
    assign out_index = beat_reg;
    assign out_time  = cur_reg.stamp;
    assign out_last  = last_beat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            beat_reg <= hksp_pkg::SEG_SPS;
        end else begin
            busy_reg <= busy_next;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

endmodule

// ===== hw/rtl/h264_keyframe_nal_splitter_core.sv =====
// ----------------------------------------------------------------------------
// h264_keyframe_nal_splitter_core
// Splits H.264 Annex B access units into SPS, PPS and rest segment descriptors.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle, except while a closed unit's record
// waits for the emitter; an SPS unit's three descriptors leave at one per cycle
// from the descriptor register while m_tready is high, a plain unit's one alone.
// Path: a unit's record passes the record register, then the descriptor register,
// and its first descriptor is valid once it is in the descriptor register.
// Reset: aresetn, synchronous, active low; after reset, units are dropped
// until an SPS-led unit closes.
module h264_keyframe_nal_splitter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] data_byte, [39:8] timestamp
    input  logic        s_tuser,   // [0] opcode
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [19:0] offset, [40:20] length, [72:41] time, zero
    output logic [1:0]  m_tuser,   // [1:0] segment_index
    output logic        m_tlast
);

    logic                 rec_valid;
    logic                 rec_ready;
    hksp_pkg::unit_rec_t  rec;
    hksp_pkg::offset_t    seg_offset;
    hksp_pkg::length_t    seg_length;
    hksp_pkg::time_t      seg_time;

    hksp_scanner u_scanner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_byte   (s_tdata[7:0]),
        .in_last   (s_tlast),
        .in_stamp  (s_tdata[39:8]),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    hksp_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec        (rec),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_offset (seg_offset),
        .out_length (seg_length),
        .out_index  (m_tuser),
        .out_time   (seg_time),
        .out_last   (m_tlast)
    );

    assign m_tdata = {7'd0, seg_time, seg_length, seg_offset};

endmodule

// ===== dv/tb_h264_keyframe_nal_splitter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_h264_keyframe_nal_splitter_core
// Streams Annex B access units into the splitter byte by byte. An in-bench
// model of the splitter predicts the SPS, PPS and rest descriptors, and every
// descriptor that comes out is compared against it. The run starts with a
// short table of hand-built units. Random units follow, mostly
// keyframes, some cut short, under three backpressure mixes.
// ----------------------------------------------------------------------------
module tb_h264_keyframe_nal_splitter_core;

    localparam logic [4:0] NAL_SEI     = 5'd6;
    localparam logic [4:0] NAL_PPS     = 5'd8;
    // Keyframe whose first start code is four bytes long and is overlapped by
    // a three-byte one. Its second start code leads an IDR slice directly.
    localparam logic [127:0] OVERLAP_UNIT = 128'h00000001_67000000_01680000_0165ff80;

    typedef struct packed {
        hksp_pkg::offset_t off;
        hksp_pkg::length_t len;
        hksp_pkg::index_t  idx;
        hksp_pkg::time_t   stamp;
        logic              fin;
    } descr_t;

    typedef struct packed {
        logic            op;
        logic [7:0]      data;
        logic            eou;
        hksp_pkg::time_t stamp;
        logic            typed;
        logic [1:0]      n_typed;
        descr_t [2:0]    typed_res;
    } stim_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    h264_keyframe_nal_splitter_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    int unsigned src_idle    = 0;
    int unsigned sink_idle   = 0;
    int          errors      = 0;
    int          items_sent  = 0;

    descr_t     descr_q [$];
    stim_t      directed [$];
    logic [7:0] unit_q [$];
    descr_t     got_want;

    // Splitter state as the model keeps it.
    logic              hunting;
    hksp_pkg::pos_t    bpos;
    logic [7:0]        win [0:4];
    logic [4:0]        nal_kind;
    logic [1:0]        codes_found;
    hksp_pkg::pos_t    sps_end;
    hksp_pkg::pos_t    pps_end;
    hksp_pkg::pos_t    rest_start;
    logic              skip_next;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic descr_t descr(hksp_pkg::offset_t off, hksp_pkg::length_t len,
                                     hksp_pkg::index_t idx, hksp_pkg::time_t ts,
                                     logic fin);
        descr_t d;
        d.off   = off;
        d.len   = len;
        d.idx   = idx;
        d.stamp = ts;
        d.fin   = fin;
        return d;
    endfunction

    function automatic stim_t make_item(logic op, logic [7:0] data, logic eou,
                                        hksp_pkg::time_t ts);
        stim_t s;
        s       = '0;
        s.op    = op;
        s.data  = data;
        s.eou   = eou;
        s.stamp = ts;
        return s;
    endfunction

    function automatic void add_row(input stim_t s);
        directed.insert(directed.size(), s);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        unit_q.insert(unit_q.size(), b);
    endfunction

    function automatic logic [7:0] pick_byte();
        int unsigned roll;
        logic [31:0] r;
        roll = $urandom_range(99);
        r    = $urandom;
        if (roll < 30) return hksp_pkg::BYTE_ZERO;
        if (roll < 45) return hksp_pkg::BYTE_ONE;
        return r[7:0];
    endfunction

    task automatic clear_unit_state();
        bpos        = '0;
        for (int k = 0; k < 5; k++) win[k] = hksp_pkg::BYTE_ZERO;
        nal_kind    = '0;
        codes_found = hksp_pkg::STAGE_NONE;
        sps_end     = '0;
        pps_end     = '0;
        rest_start  = '0;
        skip_next   = 1'b0;
    endtask

    // Tests for a start code beginning at offset 'at'; the window then holds
    // the bytes at offsets at .. at+4.
    task automatic scan_at(input hksp_pkg::pos_t at);
        logic       three;
        logic       four;
        logic [7:0] hdr;
        three = (win[0] == hksp_pkg::BYTE_ZERO) && (win[1] == hksp_pkg::BYTE_ZERO)
                && (win[2] == hksp_pkg::BYTE_ONE);
        four  = (win[0] == hksp_pkg::BYTE_ZERO) && (win[1] == hksp_pkg::BYTE_ZERO)
                && (win[2] == hksp_pkg::BYTE_ZERO) && (win[3] == hksp_pkg::BYTE_ONE);
        hdr   = (win[2] == hksp_pkg::BYTE_ONE) ? win[3] : win[4];
        if (codes_found != hksp_pkg::STAGE_DONE) begin
            if (skip_next) begin
                skip_next = 1'b0;
            end else if (three || four) begin
                skip_next = 1'b1;
                case (codes_found)
                    hksp_pkg::STAGE_NONE: begin
                        sps_end     = at;
                        codes_found = hksp_pkg::STAGE_ONE;
                    end
                    hksp_pkg::STAGE_ONE: begin
                        pps_end     = at;
                        codes_found = hksp_pkg::STAGE_TWO;
                        if ((hdr[4:0] & hksp_pkg::NAL_TYPE_MASK) == hksp_pkg::NAL_TYPE_IDR)
                        begin
                            rest_start  = at;
                            codes_found = hksp_pkg::STAGE_DONE;
                        end
                    end
                    default: begin
                        rest_start  = at;
                        codes_found = hksp_pkg::STAGE_DONE;
                    end
                endcase
            end
        end
    endtask

    // Advances the splitter model by one input transaction and returns the
    // descriptors that it closes.
    task automatic split_byte(input logic op, input logic [7:0] b, input logic eou,
                              input hksp_pkg::time_t ts, output int n,
                              output descr_t [2:0] res);
        hksp_pkg::plen_t   unit_len;
        hksp_pkg::length_t len0;
        hksp_pkg::length_t len1;
        hksp_pkg::length_t len2;
        hksp_pkg::offset_t off1;
        hksp_pkg::offset_t off2;
        n   = 0;
        res = '0;
        if (op == hksp_pkg::OP_RESYNC) begin
            hunting = 1'b1;
            return;
        end
        if (bpos != hksp_pkg::POS_MAX) begin
            for (int k = 0; k < 4; k++) win[k] = win[k+1];
            win[4] = b;
            if (bpos == 4) nal_kind = b[4:0] & hksp_pkg::NAL_TYPE_MASK;
            if (bpos >= 8) scan_at(bpos - hksp_pkg::pos_t'(4));
            bpos     = bpos + 1'b1;
            unit_len = {1'b0, bpos};
        end else begin
            // Bytes beyond the counter's range are dropped but still end the unit.
            unit_len = {1'b1, {hksp_pkg::POS_BITS{1'b0}}};
        end
        if (!eou) return;
        if (nal_kind == hksp_pkg::NAL_TYPE_SPS) hunting = 1'b0;
        if (!hunting) begin
            if (nal_kind == hksp_pkg::NAL_TYPE_SPS) begin
                len0 = '0;
                off1 = '0;
                len1 = '0;
                off2 = '0;
                len2 = '0;
                if (codes_found >= hksp_pkg::STAGE_ONE) len0 = {1'b0, sps_end};
                if (codes_found >= hksp_pkg::STAGE_TWO) begin
                    off1 = sps_end;
                    len1 = {1'b0, pps_end - sps_end};
                end
                if (codes_found == hksp_pkg::STAGE_DONE) begin
                    off2 = rest_start;
                    len2 = unit_len - {1'b0, rest_start};
                end
                res[0] = descr('0, len0, hksp_pkg::SEG_SPS, ts, 1'b0);
                res[1] = descr(off1, len1, hksp_pkg::SEG_PPS, ts, 1'b0);
                res[2] = descr(off2, len2, hksp_pkg::SEG_REST, ts, 1'b1);
                n = 3;
            end else begin
                res[0] = descr('0, unit_len, hksp_pkg::SEG_SPS, ts, 1'b1);
                n = 1;
            end
        end
        clear_unit_state();
    endtask

    task automatic send(input stim_t s);
        int           n;
        descr_t [2:0] res;
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {s.stamp, s.data};
        s_tuser  <= s.op;
        s_tlast  <= s.eou;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        split_byte(s.op, s.data, s.eou, s.stamp, n, res);
        if (s.typed) begin
            n   = int'(s.n_typed);
            res = s.typed_res;
        end
        for (int k = 0; k < n; k++) begin
            descr_q.insert(descr_q.size(), res[k]);
        end
        items_sent++;
    endtask

    task automatic push_nal(input logic [4:0] kind, input logic long_code, input int max_pay);
        logic [7:0] hdr;
        int         n;
        if (long_code || $urandom_range(1)) add_byte(hksp_pkg::BYTE_ZERO);
        add_byte(hksp_pkg::BYTE_ZERO);
        add_byte(hksp_pkg::BYTE_ZERO);
        add_byte(hksp_pkg::BYTE_ONE);
        hdr      = 8'($urandom);
        hdr[4:0] = kind;
        add_byte(hdr);
        n = $urandom_range(max_pay);
        repeat (n) add_byte(pick_byte());
    endtask

    // Mostly keyframes (SPS, PPS, optional SEI, IDR, sometimes cut short),
    // then plain units, short units and noise.
    task automatic build_unit();
        int unsigned roll;
        logic [4:0]  kind;
        unit_q.delete();
        roll = $urandom_range(99);
        if (roll < 55) begin
            push_nal(hksp_pkg::NAL_TYPE_SPS, 1'b1, 6);
            if ($urandom_range(9) != 0) begin
                push_nal(NAL_PPS, 1'b0, 4);
                if ($urandom_range(9) != 0) begin
                    if ($urandom_range(2) == 0) push_nal(NAL_SEI, 1'b0, 4);
                    push_nal(hksp_pkg::NAL_TYPE_IDR, 1'b0, 8);
                end
            end
        end else if (roll < 75) begin
            kind = 5'($urandom_range(31));
            push_nal(kind, 1'b0, 8);
        end else if (roll < 85) begin
            repeat ($urandom_range(4, 1)) add_byte(pick_byte());
        end else begin
            repeat ($urandom_range(16, 1)) add_byte(pick_byte());
        end
    endtask

    task automatic send_unit();
        hksp_pkg::time_t stamp;
        int              fin_at;
        stamp  = $urandom;
        fin_at = unit_q.size() - 1;
        if ($urandom_range(19) == 0)
            send(make_item(hksp_pkg::OP_RESYNC, 8'($urandom), 1'($urandom_range(1)),
                           $urandom));
        for (int k = 0; k <= fin_at; k++) begin
            if ($urandom_range(99) < 3)
                send(make_item(hksp_pkg::OP_RESYNC, 8'($urandom), 1'($urandom_range(1)),
                               $urandom));
            send(make_item(hksp_pkg::OP_DATA, unit_q[k], k == fin_at,
                           (k == fin_at) ? stamp : $urandom));
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (descr_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (descr_q.size() == 0) begin
                $error("descriptor transaction with nothing expected: tdata %0h", m_tdata);
                errors++;
            end else begin
                got_want = descr_q[0];
                descr_q.delete(0);
                check_field("segment_offset", 64'(got_want.off), 64'(m_tdata[19:0]));
                check_field("segment_length", 64'(got_want.len), 64'(m_tdata[40:20]));
                check_field("segment_time", 64'(got_want.stamp), 64'(m_tdata[72:41]));
                check_field("tdata padding", '0, 64'(m_tdata[79:73]));
                check_field("segment_index", 64'(got_want.idx), 64'(m_tuser));
                check_field("last_segment", 64'(got_want.fin), 64'(m_tlast));
            end
        end
    end

    initial begin
        stim_t      s;
        int         start_cnt;
        logic [7:0] b;

        hunting = 1'b1;
        clear_unit_state();

        // A one-byte unit while still waiting for a keyframe is dropped.
        s       = make_item(hksp_pkg::OP_DATA, 8'hff, 1'b1, 32'hffff_ffff);
        s.typed = 1'b1;
        add_row(s);
        // Bare SPS unit: no start code after offset 4, so all three segments are empty.
        repeat (3) add_row(make_item(hksp_pkg::OP_DATA, hksp_pkg::BYTE_ZERO, 1'b0, 32'h0));
        add_row(make_item(hksp_pkg::OP_DATA, hksp_pkg::BYTE_ONE, 1'b0, 32'h0));
        s              = make_item(hksp_pkg::OP_DATA, 8'h67, 1'b1, 32'h0);
        s.typed        = 1'b1;
        s.n_typed      = 2'd3;
        s.typed_res[0] = descr('0, '0, hksp_pkg::SEG_SPS, 32'h0, 1'b0);
        s.typed_res[1] = descr('0, '0, hksp_pkg::SEG_PPS, 32'h0, 1'b0);
        s.typed_res[2] = descr('0, '0, hksp_pkg::SEG_REST, 32'h0, 1'b1);
        add_row(s);
        // Once armed, a one-byte unit counts as a plain unit of length one.
        s              = make_item(hksp_pkg::OP_DATA, hksp_pkg::BYTE_ZERO, 1'b1, 32'h1234_5678);
        s.typed        = 1'b1;
        s.n_typed      = 2'd1;
        s.typed_res[0] = descr('0, 21'd1, hksp_pkg::SEG_SPS, 32'h1234_5678, 1'b1);
        add_row(s);
        // A resync in mid-unit re-arms the wait, but the keyframe still gets through.
        for (int i = 0; i < 16; i++) begin
            if (i == 7) begin
                s       = make_item(hksp_pkg::OP_RESYNC, 8'hff, 1'b1, 32'hffff_ffff);
                s.typed = 1'b1;
                add_row(s);
            end
            b = OVERLAP_UNIT[127 - 8*i -: 8];
            add_row(make_item(hksp_pkg::OP_DATA, b, i == 15,
                              (i == 15) ? 32'ha5a5_5a5a : 32'h0000_0000));
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_idle  = 29;
                    sink_idle = 62;
                end
                1: begin
                    src_idle  = 62;
                    sink_idle = 29;
                end
                default: begin
                    src_idle  = 0;
                    sink_idle = 0;
                end
            endcase
            if (ph == 0) begin
                foreach (directed[k]) send(directed[k]);
            end
            start_cnt = items_sent;
            while (items_sent - start_cnt < 60) begin
                build_unit();
                send_unit();
            end
            // Hold the stream until every descriptor so far has come out.
            wait_drained();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
